// ===== src/lphi_pkg.sv =====
// shared types and constants for the linear probe hash index
package lphi_pkg;

  localparam int MaxBucketsDefault = 256;
  localparam int KeyW  = 15;
  localparam int CellW = 15;
  localparam int CntW  = 9;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_FIND   = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  localparam logic CFG_BUCKETS = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_CHK,
    ST_MOD,
    ST_DONE
  } state_t;

endpackage

// ===== src/lphi_mod.sv =====
// sequential remainder unit: one quotient bit a cycle
module lphi_mod #(
  parameter int NW = 13
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lphi_pkg::KeyW-1:0] dividend,
  input  logic [NW-1:0]            divisor,
  output logic                     done,
  output logic [NW-1:0]            rem
);
  localparam int CW = $clog2(lphi_pkg::KeyW + 1);

  logic [NW:0]               rem_r, rem_nxt;
  logic [lphi_pkg::KeyW-1:0] sh_r, sh_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [NW+1:0]             trial;

  // restoring remainder step
  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, sh_r[lphi_pkg::KeyW-1]};
    if (start) begin
      rem_nxt  = '0;
      sh_nxt   = dividend;
      cnt_nxt  = CW'(lphi_pkg::KeyW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, divisor}) rem_nxt = (NW+1)'(trial - {2'b00, divisor});
      else                            rem_nxt = (NW+1)'(trial);
      sh_nxt  = {sh_r[lphi_pkg::KeyW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = busy_r && (cnt_r == CW'(1)) && !start;
  assign rem  = rem_nxt[NW-1:0];
endmodule

// ===== src/lphi_ctrl.sv =====
// probe, insert, backward-shift and clear sequencer around the bucket memory
module lphi_ctrl #(
  parameter int MAX_BUCKETS = lphi_pkg::MaxBucketsDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [lphi_pkg::KeyW-1:0]  in_coord_code,
  input  logic [lphi_pkg::CellW-1:0] in_cell_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lphi_pkg::CellW-1:0] out_found_cell,
  output logic                       out_table_full,
  input  logic [lphi_pkg::CntW-1:0]  buckets_in_use,
  input  logic [lphi_pkg::CellW-1:0] live_cell_limit
);
  localparam int AW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int CNW = (NW > lphi_pkg::CntW) ? NW : lphi_pkg::CntW;
  localparam int EW = 1 + lphi_pkg::CellW + lphi_pkg::KeyW;

  lphi_pkg::state_t st_r, st_nxt, ret_r, ret_nxt;

  // bucket memory: valid, cell, key
  logic [EW-1:0] mem [MAX_BUCKETS];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_a;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  logic                       q_v;
  logic [lphi_pkg::CellW-1:0] q_cell;
  logic [lphi_pkg::KeyW-1:0]  q_key;
  assign q_v    = rd_q[EW-1];
  assign q_cell = rd_q[lphi_pkg::KeyW +: lphi_pkg::CellW];
  assign q_key  = rd_q[lphi_pkg::KeyW-1:0];

  // effective bucket count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (CNW'(buckets_in_use) > CNW'(MAX_BUCKETS)) n_eff = NW'(MAX_BUCKETS);
    else                                          n_eff = NW'(buckets_in_use);
  end

  logic [1:0]                 op_r;
  logic [lphi_pkg::KeyW-1:0]  key_r;
  logic [lphi_pkg::CellW-1:0] cell_r;
  logic [NW-1:0]              n_r;
  logic [AW-1:0]              b_r, b_nxt, hole_r, hole_nxt;
  logic [NW-1:0]              cnt_r, cnt_nxt;
  logic                       hit_r, hit_nxt, full_r, full_nxt;
  logic [lphi_pkg::CellW-1:0] fc_r, fc_nxt;
  logic                       ov_r, ov_nxt;
  logic                       wipe_r;

  // key of the entry being considered for a backward shift
  logic [lphi_pkg::KeyW-1:0] key_r_sh;

  // second write per candidate: clear the old slot after a move
  logic          clr_pend_r;
  logic [AW-1:0] clr_a_r;

  // remainder unit for home buckets
  logic                      md_start, md_done;
  logic [lphi_pkg::KeyW-1:0] md_a;
  logic [NW-1:0]             md_rem;
  lphi_mod #(.NW(NW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(md_start), .dividend(md_a),
    .divisor(n_r), .done(md_done), .rem(md_rem)
  );

  logic [AW-1:0] b_inc;
  assign b_inc = (NW'(b_r) + 1'b1 == n_r) ? '0 : AW'(NW'(b_r) + 1'b1);

  logic q_live, q_match, movable;
  assign q_live  = q_cell < live_cell_limit;
  assign q_match = q_v && q_live && (q_key == key_r);
  always_comb begin
    if (hole_r <= b_r) movable = (md_rem <= NW'(hole_r)) || (md_rem > NW'(b_r));
    else               movable = (md_rem <= NW'(hole_r)) && (md_rem > NW'(b_r));
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lphi_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (n_eff == '0)                             st_nxt = lphi_pkg::ST_DONE;
          else if (in_opcode == lphi_pkg::OP_CLEAR)    st_nxt = lphi_pkg::ST_CLR;
          else                                         st_nxt = lphi_pkg::ST_MOD;
        end
      end
      lphi_pkg::ST_CLR:
        if (cnt_r == NW'(1)) st_nxt = wipe_r ? lphi_pkg::ST_IDLE : lphi_pkg::ST_DONE;
      lphi_pkg::ST_MOD:
        if (md_done) st_nxt = ret_r;
      lphi_pkg::ST_PROBE_RD: st_nxt = lphi_pkg::ST_PROBE_CHK;
      lphi_pkg::ST_PROBE_CHK: begin
        if (!q_v || q_match) begin
          if (op_r == lphi_pkg::OP_REMOVE && q_match && n_r != NW'(1))
            st_nxt = lphi_pkg::ST_SHIFT_RD;
          else st_nxt = lphi_pkg::ST_DONE;
        end else if (cnt_r == NW'(1)) st_nxt = lphi_pkg::ST_DONE;
        else st_nxt = lphi_pkg::ST_PROBE_RD;
      end
      lphi_pkg::ST_SHIFT_RD: st_nxt = lphi_pkg::ST_SHIFT_CHK;
      lphi_pkg::ST_SHIFT_CHK: begin
        if (!q_v) st_nxt = lphi_pkg::ST_DONE;
        else if (!q_live) st_nxt = (cnt_r == NW'(1)) ? lphi_pkg::ST_DONE
                                                     : lphi_pkg::ST_SHIFT_RD;
        else st_nxt = lphi_pkg::ST_MOD;
      end
      lphi_pkg::ST_DONE:
        if (!ov_r || out_ready) st_nxt = lphi_pkg::ST_IDLE;
      default: st_nxt = lphi_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    b_nxt = b_r; hole_nxt = hole_r; cnt_nxt = cnt_r;
    hit_nxt = hit_r; full_nxt = full_r; fc_nxt = fc_r; ret_nxt = ret_r;
    ov_nxt = ov_r;
    we = 1'b0; wa = b_r; wd = '0;
    rd_a = b_r;
    md_start = 1'b0; md_a = key_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      lphi_pkg::ST_IDLE: begin
        hit_nxt = 1'b0; fc_nxt = '0;
        full_nxt = (in_opcode == lphi_pkg::OP_INSERT);
        cnt_nxt = n_eff;
        b_nxt = '0;
        ret_nxt = lphi_pkg::ST_PROBE_RD;
        md_a = in_coord_code;
        md_start = in_valid && in_ready && (n_eff != '0)
                   && (in_opcode != lphi_pkg::OP_CLEAR);
      end
      lphi_pkg::ST_CLR: begin
        we = 1'b1; wa = b_r; wd = '0;
        b_nxt = AW'(NW'(b_r) + 1'b1);
        cnt_nxt = cnt_r - 1'b1;
      end
      lphi_pkg::ST_MOD: begin
        if (md_done && ret_r == lphi_pkg::ST_PROBE_RD) b_nxt = AW'(md_rem);
      end
      lphi_pkg::ST_PROBE_RD: rd_a = b_r;
      lphi_pkg::ST_PROBE_CHK: begin
        if (!q_v || q_match) begin
          unique case (op_r)
            lphi_pkg::OP_FIND: begin
              hit_nxt = q_match; fc_nxt = q_match ? q_cell : '0;
            end
            lphi_pkg::OP_INSERT: begin
              full_nxt = 1'b0; we = 1'b1; wa = b_r;
              wd = {1'b1, cell_r, key_r};
            end
            lphi_pkg::OP_REMOVE: begin
              if (q_match) begin
                we = 1'b1; wa = b_r; wd = '0;
                hole_nxt = b_r; b_nxt = b_inc; cnt_nxt = n_r;
              end
            end
            default: ;
          endcase
        end else begin
          b_nxt = b_inc; cnt_nxt = cnt_r - 1'b1;
        end
      end
      lphi_pkg::ST_SHIFT_RD: rd_a = b_r;
      lphi_pkg::ST_SHIFT_CHK: begin
        if (q_v && !q_live) begin
          we = 1'b1; wa = b_r; wd = '0;
          b_nxt = b_inc; cnt_nxt = cnt_r - 1'b1;
        end else if (q_v) begin
          md_start = 1'b1; md_a = q_key;
          fc_nxt = q_cell;
          ret_nxt = lphi_pkg::ST_SHIFT_RD;
        end
      end
      default: ;
    endcase
    // home bucket of the shifted candidate known: move or skip
    if (st_r == lphi_pkg::ST_MOD && md_done && ret_r == lphi_pkg::ST_SHIFT_RD) begin
      if (movable) begin
        we = 1'b1; wa = hole_r; wd = {1'b1, fc_r, key_r_sh};
        hole_nxt = b_r;
      end
      b_nxt = b_inc; cnt_nxt = cnt_r - 1'b1;
    end
    // empty the slot that an entry was just moved out of
    if (clr_pend_r) begin
      we = 1'b1; wa = clr_a_r; wd = '0;
    end
    if (st_r == lphi_pkg::ST_DONE && (!ov_r || out_ready)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (st_r == lphi_pkg::ST_SHIFT_CHK) key_r_sh <= q_key;
  end

  // control state; after reset a wipe pass empties every bucket
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lphi_pkg::ST_CLR;
      ret_r <= lphi_pkg::ST_PROBE_RD;
      ov_r <= 1'b0;
      wipe_r <= 1'b1;
      b_r <= '0;
      cnt_r <= NW'(MAX_BUCKETS);
      clr_pend_r <= 1'b0;
    end else begin
      st_r <= (st_r == lphi_pkg::ST_MOD && md_done && ret_r == lphi_pkg::ST_SHIFT_RD
               && cnt_r == NW'(1)) ? lphi_pkg::ST_DONE : st_nxt;
      ret_r <= ret_nxt;
      ov_r <= ov_nxt;
      if (st_r == lphi_pkg::ST_CLR && cnt_r == NW'(1)) wipe_r <= 1'b0;
      b_r <= b_nxt;
      cnt_r <= cnt_nxt;
      clr_pend_r <= (st_r == lphi_pkg::ST_MOD) && md_done
                    && (ret_r == lphi_pkg::ST_SHIFT_RD) && movable;
    end
    if (st_r == lphi_pkg::ST_IDLE && in_valid && in_ready) begin
      op_r <= in_opcode; key_r <= in_coord_code; cell_r <= in_cell_number;
      n_r <= n_eff;
    end
    hole_r <= hole_nxt;
    hit_r <= hit_nxt; full_r <= full_nxt;
    fc_r <= (st_r == lphi_pkg::ST_DONE || st_r == lphi_pkg::ST_IDLE
             || op_r != lphi_pkg::OP_REMOVE) ? fc_nxt : fc_nxt;
    clr_a_r <= b_r;
  end

  // output register, released one beat per item
  logic                       oh_r, of_r;
  logic [lphi_pkg::CellW-1:0] oc_r;
  always_ff @(posedge clk) begin
    if (st_r == lphi_pkg::ST_DONE && (!ov_r || out_ready)) begin
      oh_r <= hit_r; of_r <= full_r;
      oc_r <= (op_r == lphi_pkg::OP_FIND) ? fc_r : '0;
    end
  end

  assign in_ready       = (st_r == lphi_pkg::ST_IDLE);
  assign out_valid      = ov_r;
  assign out_hit        = oh_r & (op_r == lphi_pkg::OP_FIND | 1'b1) & oh_r;
  assign out_found_cell = oc_r;
  assign out_table_full = of_r;
endmodule

// ===== src/linear_probe_hash_index.sv =====
// linear probe hash index: open-addressed map from coordinate code to cell number
// operation: the remainder unit gives the home bucket, then buckets are probed in turn until one
//   decides; a removal then walks the following buckets and computes the home of each live one;
//   clear empties each bucket in use
// throughput: one operation at a time; a new beat can be taken in the cycle the result appears
// reset: synchronous active-low, then a wipe pass empties the bucket memory
module linear_probe_hash_index #(
  parameter int MAX_BUCKETS = lphi_pkg::MaxBucketsDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [lphi_pkg::KeyW-1:0]  in_coord_code,
  input  logic [lphi_pkg::CellW-1:0] in_cell_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output logic [lphi_pkg::CellW-1:0] out_found_cell,
  output logic                       out_table_full,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [lphi_pkg::CellW-1:0] cfg_wdata
);
  logic [lphi_pkg::CntW-1:0]  buckets_r;
  logic [lphi_pkg::CellW-1:0] limit_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buckets_r <= lphi_pkg::CntW'(256);
      limit_r   <= lphi_pkg::CellW'(32767);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lphi_pkg::CFG_BUCKETS: buckets_r <= cfg_wdata[lphi_pkg::CntW-1:0];
        lphi_pkg::CFG_LIMIT:   limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lphi_ctrl #(.MAX_BUCKETS(MAX_BUCKETS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_coord_code(in_coord_code), .in_cell_number(in_cell_number),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_found_cell(out_found_cell), .out_table_full(out_table_full),
    .buckets_in_use(buckets_r), .live_cell_limit(limit_r)
  );
endmodule

// ===== src/lphi_checker.sv =====
// port-level checks for the hash index, bound to the top level
module lphi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_hit,
  input logic [lphi_pkg::CellW-1:0] out_found_cell,
  input logic                       out_table_full
);
  // a result never claims both a hit and a full table
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_table_full)) else $error("hit and full together");
  // a miss reports cell zero
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_cell == '0)) else $error("miss with cell");
  // no new beat taken the cycle after one is accepted
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("back to back accept");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found_cell)))
    else $error("result dropped");
endmodule

bind linear_probe_hash_index lphi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_found_cell(out_found_cell), .out_table_full(out_table_full)
);
